// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, held off during reset
`define ASSERT_SYNC(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// checked at every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/core/lcdfb_pkg.sv =====
`default_nettype none
package lcdfb_pkg;

   localparam int FRAME_BYTES = 1024;
   localparam int TILE_COUNT  = 128;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int TILE_W      = $clog2(TILE_COUNT);

   localparam logic [1:0] KIND_PAGE = 2'd0;
   localparam logic [1:0] KIND_COL  = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [7:0] x;
      logic [7:0] y;
      logic       color;
      logic [6:0] tile;
   } req_type;

   typedef struct packed {
      logic       chip;
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic clr_wr;
      logic pix_rd;
      logic pix_wr;
      logic fl_rd;
      logic clr_dirty;
      logic emit_page;
      logic emit_col;
      logic emit_data;
      logic cnt_clr;
      logic cnt_inc;
   } cmd_type;

   typedef struct packed {
      logic pix_ok;
      logic dirty_hit;
      logic cnt_full;
      logic cnt_eight;
   } stat_type;

endpackage
`default_nettype wire

// ===== rtl/core/lcdfb_ctrl.sv =====
`default_nettype none
module lcdfb_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 mode,
   input  lcdfb_pkg::stat_type stat,
   output lcdfb_pkg::cmd_type  cmd,
   output logic                busy
);
   import lcdfb_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_FL_PAGE,
      ST_FL_COL,
      ST_FL_DATA
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr  = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = mode ? ST_FL_PAGE : ST_PIX_RD;
            end
         end
         ST_PIX_RD: begin
            if (stat.pix_ok) begin
               cmd.pix_rd = 1'b1;
               state_in   = ST_PIX_WR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PIX_WR: begin
            cmd.pix_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_FL_PAGE: begin
            if (stat.dirty_hit) begin
               cmd.clr_dirty = 1'b1;
               cmd.emit_page = 1'b1;
               cmd.cnt_clr   = 1'b1;
               state_in      = ST_FL_COL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FL_COL: begin
            cmd.emit_col = 1'b1;
            cmd.fl_rd    = 1'b1;
            cmd.cnt_inc  = 1'b1;
            state_in     = ST_FL_DATA;
         end
         ST_FL_DATA: begin
            cmd.emit_data = 1'b1;
            cmd.fl_rd     = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (stat.cnt_eight) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/lcdfb_dp.sv =====
`default_nettype none
module lcdfb_dp (
   input  wire                 clock,
   input  wire                 reset,
   input  lcdfb_pkg::req_type  req_data,
   input  lcdfb_pkg::cmd_type  cmd,
   output lcdfb_pkg::stat_type stat,
   output logic                rsp_valid,
   output lcdfb_pkg::rsp_type  rsp_data
);
   import lcdfb_pkg::*;

   logic [7:0]          mem [FRAME_BYTES];
   req_type             req_ff;
   logic [7:0]          rd_ff;
   logic [ADDR_W-1:0]   cnt_ff;
   logic [ADDR_W-1:0]   cnt_in;
   logic [TILE_COUNT-1:0] dirty_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic [ADDR_W-1:0]   pix_addr;
   logic [TILE_W-1:0]   pix_tile;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic [7:0]          mask;
   logic                rd_en;
   logic                wr_en;

   assign pix_addr = {req_ff.x[6], req_ff.y[5:3], req_ff.x[5:0]};
   assign pix_tile = {req_ff.x[6], req_ff.y[5:3], req_ff.x[5:3]};
   assign mask     = 8'd1 << req_ff.y[2:0];

   assign stat.pix_ok    = ~req_ff.x[7] & (req_ff.y[7:6] == 2'd0);
   assign stat.dirty_hit = dirty_ff[req_ff.tile];
   assign stat.cnt_full  = (cnt_ff == ADDR_W'(FRAME_BYTES - 1));
   assign stat.cnt_eight = cnt_ff[3];

   assign rd_en   = cmd.pix_rd | cmd.fl_rd;
   assign rd_addr = cmd.pix_rd ? pix_addr : {req_ff.tile, cnt_ff[2:0]};
   assign wr_en   = cmd.clr_wr | cmd.pix_wr;
   assign wr_addr = cmd.clr_wr ? cnt_ff : pix_addr;
   assign wr_data = cmd.clr_wr ? 8'd0 :
                    (req_ff.color ? (rd_ff | mask) : (rd_ff & ~mask));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      priority if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = cmd.emit_page | cmd.emit_col | cmd.emit_data;
      rsp_in.chip  = req_ff.tile[6];
      rsp_in.last  = 1'b0;
      priority if (cmd.emit_page) begin
         rsp_in.kind  = KIND_PAGE;
         rsp_in.value = {5'd0, req_ff.tile[5:3]};
      end else if (cmd.emit_col) begin
         rsp_in.kind  = KIND_COL;
         rsp_in.value = {2'd0, req_ff.tile[2:0], 3'd0};
      end else begin
         rsp_in.kind  = KIND_DATA;
         rsp_in.value = rd_ff;
         rsp_in.last  = cnt_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.pix_rd) begin
            dirty_ff[pix_tile] <= 1'b1;
         end
         if (cmd.clr_dirty) begin
            dirty_ff[req_ff.tile] <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/lcd_framebuffer_dirty_tile_flush.sv =====
// a dirty tile flush gives a page command, a column command and eight data bytes back to back, all registered;
// a new transaction is taken only back in idle, after a dirty flush, a clean one, a pixel write (read, then
// write back) or an ignored pixel
// the frame memory takes one access at a time: one byte read or written per cycle
// reset clears the dirty marks at once, then a pass over all 1024 bytes zeroes the frame memory
// with busy high; results are never held off by the receiver
`default_nettype none
`include "assert_macros.svh"
module lcd_framebuffer_dirty_tile_flush (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  lcdfb_pkg::req_type req_data,
   output logic               busy,
   output logic               rsp_valid,
   output lcdfb_pkg::rsp_type rsp_data
);
   import lcdfb_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     page_out;
   logic     col_out;

   lcdfb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mode  (req_data.mode),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   lcdfb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign page_out = rsp_valid && (rsp_data.kind == KIND_PAGE);
   assign col_out  = rsp_valid && (rsp_data.kind == KIND_COL);

   // an accepted transaction always leaves idle: busy is high in the next cycle
   `ASSERT_SYNC(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   // page command is followed by the column command of the same half
   `ASSERT_SYNC(a_page_then_col, clock, reset, page_out |=> (col_out && $stable(rsp_data.chip)))
   // nothing follows the final data byte
   `ASSERT_SYNC(a_last_ends, clock, reset, (rsp_valid && rsp_data.last) |=> !rsp_valid)
   // memory clear pass only while busy
   `ASSERT_ALWAYS(a_clear_busy, clock, cmd.clr_wr |-> busy)

endmodule
`default_nettype wire
